### rtl/ffa_pkg.sv
// Shared types and constants for the first-fit allocator with oldest eviction.
// Holds field widths, the result status codes and the controller/datapath
// command and status bundles. Depends on nothing.
`default_nettype none

package ffa_pkg;

  localparam int unsigned MEM_UNITS_DEF  = 1024;
  localparam int unsigned PROC_SLOTS_DEF = 16;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned START_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CFG_W-1:0] TOTAL_RST = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_RST = 11'd1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED    = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_FREED        = 3'd2,
    ST_NOT_RESIDENT = 3'd3,
    ST_ALREADY      = 3'd4
  } status_e;

  typedef enum logic {
    REG_TOTAL = 1'b0,
    REG_FRAME = 1'b1
  } reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    alloc_clr;
    logic    clr_init;
    logic    clr_step;
    logic    req_load;
    logic    scan_step;
    logic    div_go;
    logic    div_cap;
    logic    rel_init;
    logic    rel_evict;
    logic    rel_step;
    logic    rel_done;
    logic    find_init;
    logic    find_step;
    logic    fill_step;
    logic    commit;
    logic    res_load;
    status_e res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic is_free_op;
    logic hit;
    logic flat;
    logic need_zero;
    logic div_done;
    logic short_now;
    logic any_valid;
    logic rel_empty;
    logic find_hit;
    logic find_end;
    logic fill_empty;
  } sts_t;

endpackage

`default_nettype wire

### rtl/ffa_req_if.sv
// Request channel of the allocator: valid/ready plus the request fields.
// Depends on ffa_pkg for the field widths.
`default_nettype none

interface ffa_req_if import ffa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   process_id;
  logic [SIZE_W-1:0] mem_size;

  modport source (output valid, action, process_id, mem_size, input ready);
  modport sink   (input valid, action, process_id, mem_size, output ready);
endinterface

`default_nettype wire

### rtl/ffa_rsp_if.sv
// Response channel of the allocator: valid/ready plus the result fields.
// Depends on ffa_pkg for the field widths.
`default_nettype none

interface ffa_rsp_if import ffa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_unit;
  logic [SIZE_W-1:0]   pages_granted;
  logic                evicted;
  logic [ID_W-1:0]     evicted_id;
  logic [SIZE_W-1:0]   used_amount;

  modport source (output valid, status, start_unit, pages_granted, evicted, evicted_id,
                  used_amount, input ready);
  modport sink   (input valid, status, start_unit, pages_granted, evicted, evicted_id,
                  used_amount, output ready);
endinterface

`default_nettype wire

### rtl/ffa_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Stand-alone; used by the allocator datapath for frame counts.
`default_nettype none

module ffa_div #(
  parameter int unsigned W = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o
);

  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [W:0]      rem_q;
  logic [W-1:0]    quo_q;
  logic [W:0]      rem_sh;
  logic            ge;

  assign rem_sh     = {rem_q[W-1:0], quo_q[W-1]};
  assign ge         = rem_sh >= {1'b0, divisor_i};
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### rtl/ffa_dp.sv
// Allocator datapath: unit bitmap memory, process slot table, counters,
// run search, release and fill sweeps. Depends on ffa_pkg and ffa_div.
`default_nettype none

module ffa_dp import ffa_pkg::*; #(
  parameter int unsigned MEM_UNITS  = MEM_UNITS_DEF,
  parameter int unsigned PROC_SLOTS = PROC_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [CFG_W-1:0]    total_i,
  input  wire logic [CFG_W-1:0]    frame_i,
  input  wire logic                action_i,
  input  wire logic [ID_W-1:0]     process_id_i,
  input  wire logic [SIZE_W-1:0]   mem_size_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [START_W-1:0]       start_unit_o,
  output logic [SIZE_W-1:0]        pages_granted_o,
  output logic                     evicted_o,
  output logic [ID_W-1:0]          evicted_id_o,
  output logic [SIZE_W-1:0]        used_amount_o
);

  localparam int unsigned UW  = $clog2(MEM_UNITS);
  localparam int unsigned CW  = $clog2(MEM_UNITS + 1);
  localparam int unsigned AW  = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int unsigned SW  = $clog2(PROC_SLOTS);

  // Request.
  logic              act_q;
  logic [ID_W-1:0]   id_q;
  logic [SIZE_W-1:0] size_q;

  // Effective configuration.
  logic [AW-1:0] total_ext, eff_total, eff_frame;
  logic          flat;

  assign total_ext = AW'(total_i);
  assign eff_total = (total_ext > AW'(MEM_UNITS)) ? AW'(MEM_UNITS) : total_ext;
  assign eff_frame = (frame_i == '0) ? AW'(1) : AW'(frame_i);
  assign flat      = (eff_frame == eff_total);

  // Slot table.
  logic [PROC_SLOTS-1:0] valid_q;
  logic [ID_W-1:0]       owner_q  [PROC_SLOTS];
  logic [UW-1:0]         first_q  [PROC_SLOTS];
  logic [SEQ_W-1:0]      seqs_q   [PROC_SLOTS];
  logic [CW-1:0]         frames_q [PROC_SLOTS];

  // Scan results.
  logic [SW-1:0]    scan_idx_q;
  logic             hit_q, free_found_q, old_found_q;
  logic [SW-1:0]    hit_idx_q, free_idx_q, old_idx_q;
  logic [UW-1:0]    hit_first_q, old_first_q;
  logic [CW-1:0]    hit_frames_q, old_frames_q;
  logic [SEQ_W-1:0] old_seq_q;
  logic [ID_W-1:0]  old_owner_q;

  // Amounts.
  logic [AW-1:0]    need_q, cap_q;
  logic             div_sel_q;
  logic             ev_q;
  logic [CW-1:0]    used_units_q, used_units_d, used_frames_q, used_frames_d;
  logic [SEQ_W-1:0] seq_q;

  // Sweeps.
  logic [UW-1:0] clr_addr_q;
  logic [SW-1:0] rel_slot_q;
  logic [UW-1:0] rel_ptr_q;
  logic [CW-1:0] rel_cnt_q, rel_frames_q;
  logic [CW-1:0] rd_addr_q;
  logic          rd_vld_q;
  logic [UW-1:0] unit_q;
  logic [AW-1:0] run_q;
  logic [UW-1:0] start_q, fill_ptr_q;
  logic [CW-1:0] fill_cnt_q;

  // Bitmap memory.
  logic          map_mem [MEM_UNITS];
  logic          map_rd_q;
  logic          map_we, map_wdata;
  logic [UW-1:0] map_waddr;

  // Divider.
  logic [AW-1:0] div_dividend, div_quo;
  logic          div_done;

  assign div_dividend = cmd_i.div_cap ? eff_total
                                      : (AW'(size_q) + eff_frame - AW'(1));

  ffa_div #(.W(AW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (eff_frame),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Scan of the current slot.
  logic cur_v, cur_match, cur_older;
  assign cur_v     = valid_q[scan_idx_q];
  assign cur_match = cur_v && (owner_q[scan_idx_q] == id_q);
  assign cur_older = cur_v && (!old_found_q || (seqs_q[scan_idx_q] < old_seq_q));

  // Space check.
  logic [CW-1:0] used_cur;
  logic [AW:0]   used_sum;
  logic          short_now;
  assign used_cur  = flat ? used_units_q : used_frames_q;
  assign used_sum  = (AW+1)'(used_cur) + (AW+1)'(need_q);
  assign short_now = (used_sum > (AW+1)'(cap_q)) || !(free_found_q || ev_q);

  // Run search.
  logic          issue, find_hit;
  logic [AW-1:0] run_inc, run_start;
  assign issue     = AW'(rd_addr_q) < eff_total;
  assign run_inc   = run_q + AW'(1);
  assign find_hit  = rd_vld_q && !map_rd_q && (run_inc == need_q);
  assign run_start = AW'(unit_q) + AW'(1) - need_q;

  // Slot that receives a new allocation: after an eviction the lowest free one.
  logic [SW-1:0] commit_idx;
  always_comb begin
    commit_idx = free_idx_q;
    if (ev_q && !(free_found_q && (free_idx_q < old_idx_q))) begin
      commit_idx = old_idx_q;
    end
  end

  // Used counts.
  always_comb begin
    used_units_d  = used_units_q;
    used_frames_d = used_frames_q;
    if (cmd_i.alloc_clr) begin
      used_units_d  = '0;
      used_frames_d = '0;
    end else if (cmd_i.rel_done) begin
      if (flat) begin
        used_units_d = (used_units_q >= rel_frames_q) ? used_units_q - rel_frames_q : '0;
      end else begin
        used_frames_d = (used_frames_q >= rel_frames_q) ? used_frames_q - rel_frames_q : '0;
      end
    end else if (cmd_i.commit) begin
      if (flat) begin
        used_units_d = used_units_q + CW'(need_q);
      end else begin
        used_frames_d = used_frames_q + CW'(need_q);
      end
    end
  end

  // Bitmap write port.
  always_comb begin
    map_we    = 1'b0;
    map_wdata = 1'b0;
    map_waddr = clr_addr_q;
    if (cmd_i.clr_step) begin
      map_we = 1'b1;
    end else if (cmd_i.rel_step) begin
      map_we    = 1'b1;
      map_waddr = rel_ptr_q;
    end else if (cmd_i.fill_step) begin
      map_we    = 1'b1;
      map_wdata = 1'b1;
      map_waddr = fill_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[rd_addr_q[UW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      used_units_q  <= '0;
      used_frames_q <= '0;
      seq_q         <= '0;
      clr_addr_q    <= '0;
      scan_idx_q    <= '0;
      hit_q         <= 1'b0;
      free_found_q  <= 1'b0;
      old_found_q   <= 1'b0;
      ev_q          <= 1'b0;
      div_sel_q     <= 1'b0;
      rd_vld_q      <= 1'b0;
      rel_cnt_q     <= '0;
      fill_cnt_q    <= '0;
    end else begin
      used_units_q  <= used_units_d;
      used_frames_q <= used_frames_d;
      if (cmd_i.alloc_clr) begin
        valid_q <= '0;
      end else if (cmd_i.rel_done) begin
        valid_q[rel_slot_q] <= 1'b0;
      end else if (cmd_i.commit) begin
        valid_q[commit_idx] <= 1'b1;
      end
      if (cmd_i.commit) begin
        seq_q <= seq_q + 1'b1;
      end
      if (cmd_i.clr_init) begin
        clr_addr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_addr_q <= (clr_addr_q == UW'(MEM_UNITS - 1)) ? '0 : clr_addr_q + 1'b1;
      end
      if (cmd_i.req_load) begin
        scan_idx_q   <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
        old_found_q  <= 1'b0;
        ev_q         <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (cur_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!cur_v && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (cur_older) begin
          old_found_q <= 1'b1;
        end
      end
      if (cmd_i.rel_init && cmd_i.rel_evict) begin
        ev_q <= 1'b1;
      end
      if (cmd_i.div_go) begin
        div_sel_q <= cmd_i.div_cap;
      end
      if (cmd_i.find_init) begin
        rd_vld_q <= 1'b0;
      end else if (cmd_i.find_step) begin
        rd_vld_q <= issue;
      end
      if (cmd_i.rel_init) begin
        rel_cnt_q <= flat ? (cmd_i.rel_evict ? old_frames_q : hit_frames_q) : '0;
      end else if (cmd_i.rel_step) begin
        rel_cnt_q <= rel_cnt_q - 1'b1;
      end
      if (cmd_i.find_step && find_hit) begin
        fill_cnt_q <= CW'(need_q);
      end else if (cmd_i.fill_step) begin
        fill_cnt_q <= fill_cnt_q - 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q   <= action_i;
      id_q    <= process_id_i;
      size_q  <= mem_size_i;
      start_q <= '0;
    end
    if (cmd_i.req_load && flat) begin
      need_q <= AW'(mem_size_i);
      cap_q  <= eff_total;
    end else if (div_done) begin
      if (div_sel_q) begin
        cap_q <= div_quo;
      end else begin
        need_q <= div_quo;
      end
    end
    if (cmd_i.scan_step) begin
      if (cur_match && !hit_q) begin
        hit_idx_q    <= scan_idx_q;
        hit_first_q  <= first_q[scan_idx_q];
        hit_frames_q <= frames_q[scan_idx_q];
      end
      if (!cur_v && !free_found_q) begin
        free_idx_q <= scan_idx_q;
      end
      if (cur_older) begin
        old_idx_q    <= scan_idx_q;
        old_seq_q    <= seqs_q[scan_idx_q];
        old_first_q  <= first_q[scan_idx_q];
        old_frames_q <= frames_q[scan_idx_q];
        old_owner_q  <= owner_q[scan_idx_q];
      end
    end
    if (cmd_i.rel_init) begin
      rel_slot_q   <= cmd_i.rel_evict ? old_idx_q : hit_idx_q;
      rel_ptr_q    <= cmd_i.rel_evict ? old_first_q : hit_first_q;
      rel_frames_q <= cmd_i.rel_evict ? old_frames_q : hit_frames_q;
    end else if (cmd_i.rel_step) begin
      rel_ptr_q <= rel_ptr_q + 1'b1;
    end
    if (cmd_i.find_init) begin
      rd_addr_q <= '0;
      run_q     <= '0;
    end else if (cmd_i.find_step) begin
      if (issue) begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      unit_q <= rd_addr_q[UW-1:0];
      if (rd_vld_q) begin
        run_q <= map_rd_q ? '0 : run_inc;
      end
      if (find_hit) begin
        start_q    <= UW'(run_start);
        fill_ptr_q <= UW'(run_start);
      end
    end else if (cmd_i.fill_step) begin
      fill_ptr_q <= fill_ptr_q + 1'b1;
    end
    if (cmd_i.commit) begin
      owner_q[commit_idx]  <= id_q;
      first_q[commit_idx]  <= start_q;
      seqs_q[commit_idx]   <= seq_q;
      frames_q[commit_idx] <= CW'(need_q);
    end
    if (cmd_i.res_load) begin
      status_o        <= cmd_i.res_status;
      start_unit_o    <= (cmd_i.res_status == ST_ALLOCATED) ? START_W'(start_q) : '0;
      pages_granted_o <= (cmd_i.res_status == ST_ALLOCATED) ? SIZE_W'(need_q) : '0;
      evicted_o       <= ev_q;
      evicted_id_o    <= ev_q ? old_owner_q : '0;
      used_amount_o   <= flat ? SIZE_W'(used_units_d) : SIZE_W'(used_frames_d);
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_last   = (clr_addr_q == UW'(MEM_UNITS - 1));
    sts_o.scan_last  = (scan_idx_q == SW'(PROC_SLOTS - 1));
    sts_o.is_free_op = act_q;
    sts_o.hit        = hit_q;
    sts_o.flat       = flat;
    sts_o.need_zero  = (need_q == '0);
    sts_o.div_done   = div_done;
    sts_o.short_now  = short_now;
    sts_o.any_valid  = old_found_q;
    sts_o.rel_empty  = (rel_cnt_q == '0);
    sts_o.find_hit   = find_hit;
    sts_o.find_end   = !rd_vld_q && !issue;
    sts_o.fill_empty = (fill_cnt_q == '0);
  end

endmodule

`default_nettype wire

### rtl/ffa_ctrl.sv
// Allocator controller: one-hot state machine that sequences the datapath.
// Depends on ffa_pkg for the command and status bundles.
`default_nettype none

module ffa_ctrl import ffa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_wr_i,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_SCAN     = 13'b0000000000100,
    S_DECIDE   = 13'b0000000001000,
    S_DIV_NEED = 13'b0000000010000,
    S_DIV_CAP  = 13'b0000000100000,
    S_CHECK    = 13'b0000001000000,
    S_RELEASE  = 13'b0000010000000,
    S_RECHECK  = 13'b0000100000000,
    S_FIND     = 13'b0001000000000,
    S_FILL     = 13'b0010000000000,
    S_COMMIT   = 13'b0100000000000,
    S_RESP     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  state_e place_state;

  // Flat requests that need units search the bitmap; the rest commit at once.
  assign place_state = (sts_i.flat && !sts_i.need_zero) ? S_FIND : S_COMMIT;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.res_status  = ST_ALLOCATED;
    req_ready_o       = 1'b0;
    rsp_valid_o       = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_free_op) begin
          if (sts_i.hit) begin
            cmd_o.rel_init = 1'b1;
            state_d        = S_RELEASE;
          end else begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_NOT_RESIDENT;
            state_d          = S_RESP;
          end
        end else if (sts_i.hit) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_ALREADY;
          state_d          = S_RESP;
        end else if (sts_i.flat) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d      = S_DIV_NEED;
        end
      end
      S_DIV_NEED: begin
        if (sts_i.div_done) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_cap = 1'b1;
          state_d       = S_DIV_CAP;
        end
      end
      S_DIV_CAP: begin
        if (sts_i.div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.short_now) begin
          cmd_o.find_init = 1'b1;
          state_d         = place_state;
        end else if (sts_i.any_valid) begin
          cmd_o.rel_init  = 1'b1;
          cmd_o.rel_evict = 1'b1;
          state_d         = S_RELEASE;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_RESP;
        end
      end
      S_RELEASE: begin
        if (sts_i.rel_empty) begin
          cmd_o.rel_done = 1'b1;
          if (sts_i.is_free_op) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_FREED;
            state_d          = S_RESP;
          end else begin
            state_d = S_RECHECK;
          end
        end else begin
          cmd_o.rel_step = 1'b1;
        end
      end
      S_RECHECK: begin
        if (sts_i.short_now) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_RESP;
        end else begin
          cmd_o.find_init = 1'b1;
          state_d         = place_state;
        end
      end
      S_FIND: begin
        cmd_o.find_step = 1'b1;
        if (sts_i.find_hit) begin
          state_d = S_FILL;
        end else if (sts_i.find_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_RESP;
        end
      end
      S_FILL: begin
        if (sts_i.fill_empty) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.fill_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit     = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_ALLOCATED;
        state_d          = S_RESP;
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // A register write drops every allocation and restarts the bitmap clear.
    if (cfg_wr_i) begin
      cmd_o.alloc_clr = 1'b1;
      cmd_o.clr_init  = 1'b1;
      cmd_o.clr_step  = 1'b0;
      state_d         = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/first_fit_allocator_oldest_evict_core.sv
// Top level of the first-fit allocator with oldest-first eviction.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl and ffa_dp.
//
//   Channel  Direction  Handshake             Beat contents
//   req_i    in         valid / ready         action, process_id, mem_size
//   rsp_o    out        valid / ready         status, start_unit, pages_granted,
//                                             evicted, evicted_id, used_amount
//   APB      in         psel/penable/pready   total_units (0x0), frame_size (0x4)
//
// One request is in flight at a time; it returns one response beat.
// A request first scans all PROC_SLOTS entries of the slot table and then
// decides. Paging mode adds two divisions on the 12-bit divider, one for the
// frames needed and one for the frame capacity. In flat mode an eviction
// clears the released units one at a time, and placement adds a bitmap scan
// over up to the effective total units (one bitmap read a cycle) and then
// marks the granted units one at a time.
// After reset and after every register write the whole bitmap of MEM_UNITS
// units is cleared, one unit per cycle, with req_i not ready.
// The response is held in a register until rsp_o is taken; a stalled response
// holds the next request off.
`default_nettype none

module first_fit_allocator_oldest_evict_core import ffa_pkg::*; #(
  parameter int unsigned MEM_UNITS  = MEM_UNITS_DEF,
  parameter int unsigned PROC_SLOTS = PROC_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ffa_req_if.sink                req_i,
  ffa_rsp_if.source              rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Configuration registers. Registers sit on a four-byte stride, so the
  // word select is address bit 2; the byte offset bits do not decode.
  logic [CFG_W-1:0] total_q, frame_q;
  logic             cfg_wr;
  reg_e             reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RST;
      frame_q <= FRAME_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TOTAL: total_q <= pwdata[CFG_W-1:0];
        REG_FRAME: frame_q <= pwdata[CFG_W-1:0];
        default:   total_q <= total_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TOTAL: prdata = APB_DW'(total_q);
      REG_FRAME: prdata = APB_DW'(frame_q);
      default:   prdata = '0;
    endcase
  end

  // The controller sequences; the datapath holds the bitmap, slot table and
  // counters and registers the response beat.
  cmd_t cmd;
  sts_t sts;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffa_dp #(
    .MEM_UNITS  (MEM_UNITS),
    .PROC_SLOTS (PROC_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .total_i         (total_q),
    .frame_i         (frame_q),
    .action_i        (req_i.action),
    .process_id_i    (req_i.process_id),
    .mem_size_i      (req_i.mem_size),
    .status_o        (rsp_o.status),
    .start_unit_o    (rsp_o.start_unit),
    .pages_granted_o (rsp_o.pages_granted),
    .evicted_o       (rsp_o.evicted),
    .evicted_id_o    (rsp_o.evicted_id),
    .used_amount_o   (rsp_o.used_amount)
  );

endmodule

`default_nettype wire

### rtl/ffa_chk.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on ffa_pkg for the status codes.
`default_nettype none

module ffa_chk import ffa_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_ready_i,
  input wire logic                rsp_valid_i,
  input wire logic                rsp_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [START_W-1:0]  start_unit_i,
  input wire logic [SIZE_W-1:0]   pages_granted_i,
  input wire logic                evicted_i,
  input wire logic [ID_W-1:0]     evicted_id_i,
  input wire logic [SIZE_W-1:0]   used_amount_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
    $stable(used_amount_i))
    else $error("response beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request taken while a response is pending");

  a_evict_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && evicted_i |->
    status_i == ST_ALLOCATED || status_i == ST_NO_SPACE)
    else $error("eviction reported on a request that cannot evict");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_ALLOCATED |-> start_unit_i == '0 && pages_granted_i == '0)
    else $error("grant reported on a failed or free request");

  a_evict_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !evicted_i |-> evicted_id_i == '0)
    else $error("evicted id set without an eviction");

endmodule

bind first_fit_allocator_oldest_evict_core ffa_chk u_ffa_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .start_unit_i    (rsp_o.start_unit),
  .pages_granted_i (rsp_o.pages_granted),
  .evicted_i       (rsp_o.evicted),
  .evicted_id_i    (rsp_o.evicted_id),
  .used_amount_i   (rsp_o.used_amount)
);

`default_nettype wire

### tb/ffa_tb_if.sv
// Testbench-side copies are not needed; this file holds the APB driver bundle.
// Depends on ffa_pkg for the APB widths.
`timescale 1ns / 100ps

interface ffa_apb_tb_if import ffa_pkg::*;;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
endinterface

### tb/first_fit_allocator_oldest_evict_core_test.sv
// Self-checking test of the first-fit allocator with oldest-first eviction.
// Drives requests and register writes, predicts every response beat with an
// internal allocator model and compares field by field. Needs ffa_pkg, the
// request/response interfaces and the APB bundle.
`timescale 1ns / 100ps

module first_fit_allocator_oldest_evict_core_test;
  import ffa_pkg::*;

  localparam int NUNITS = 1024;
  localparam int NSLOTS = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   process_id;
    logic [SIZE_W-1:0] mem_size;
  } request_t;

  typedef struct packed {
    status_e             status;
    logic [START_W-1:0]  start_unit;
    logic [SIZE_W-1:0]   pages_granted;
    logic                evicted;
    logic [ID_W-1:0]     evicted_id;
    logic [SIZE_W-1:0]   used_amount;
  } answer_t;

  // A directed row: the request and, where it is plain, the typed-in answer.
  typedef struct {
    request_t req;
    bit       has_ans;
    answer_t  ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();
  ffa_apb_tb_if apb ();

  first_fit_allocator_oldest_evict_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (apb.psel),
    .penable(apb.penable),
    .pwrite (apb.pwrite),
    .paddr  (apb.paddr),
    .pwdata (apb.pwdata),
    .prdata (apb.prdata),
    .pready (apb.pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Allocator state mirrored by the predictor.
  int unsigned      mdl_total, mdl_frame;
  bit               unit_busy [NUNITS];
  bit               slot_live [NSLOTS];
  logic [ID_W-1:0]  slot_pid  [NSLOTS];
  int unsigned      slot_base [NSLOTS];
  int unsigned      slot_amt  [NSLOTS];
  logic [31:0]      slot_age  [NSLOTS];
  int unsigned      units_in_use, frames_in_use;
  logic [31:0]      alloc_seq;

  answer_t     pending_answers [$];
  request_t    send_queue [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          rsp_stall_long = 0;

  function automatic int unsigned eff_total();
    return mdl_total > NUNITS ? NUNITS : mdl_total;
  endfunction

  function automatic int unsigned eff_frame();
    return mdl_frame == 0 ? 1 : mdl_frame;
  endfunction

  function automatic bit flat_mode();
    return eff_frame() == eff_total();
  endfunction

  function automatic void wipe_allocations();
    foreach (unit_busy[i]) unit_busy[i] = 0;
    foreach (slot_live[i]) slot_live[i] = 0;
    units_in_use = 0;
    frames_in_use = 0;
  endfunction

  function automatic int slot_of(logic [ID_W-1:0] pid);
    for (int s = 0; s < NSLOTS; s++)
      if (slot_live[s] && slot_pid[s] == pid) return s;
    return -1;
  endfunction

  function automatic int empty_slot();
    for (int s = 0; s < NSLOTS; s++)
      if (!slot_live[s]) return s;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    if (flat_mode()) begin
      for (int unsigned i = 0; i < slot_amt[s]; i++) begin
        int unsigned u;
        u = slot_base[s] + i;
        if (u < NUNITS && unit_busy[u]) begin
          unit_busy[u] = 0;
          if (units_in_use > 0) units_in_use--;
        end
      end
    end else begin
      frames_in_use = frames_in_use >= slot_amt[s] ? frames_in_use - slot_amt[s] : 0;
    end
    slot_live[s] = 0;
  endfunction

  // Works out the answer to one request and advances the mirrored state.
  function automatic answer_t allocate_or_free(request_t r);
    answer_t a;
    int s;
    bit flat;
    int unsigned need, cap, used, start, run;
    bit ok, found;
    a = '0;
    flat = flat_mode();
    s = slot_of(r.process_id);
    if (r.action) begin
      if (s >= 0) begin
        drop_slot(s);
        a.status = ST_FREED;
      end else begin
        a.status = ST_NOT_RESIDENT;
      end
    end else if (s >= 0) begin
      a.status = ST_ALREADY;
    end else begin
      need = flat ? r.mem_size : (r.mem_size + eff_frame() - 1) / eff_frame();
      cap = flat ? eff_total() : eff_total() / eff_frame();
      used = flat ? units_in_use : frames_in_use;
      ok = 1;
      start = 0;
      if (used + need > cap || empty_slot() < 0) begin
        int o;
        o = -1;
        for (int k = 0; k < NSLOTS; k++)
          if (slot_live[k] && (o < 0 || slot_age[k] < slot_age[o])) o = k;
        if (o < 0) begin
          ok = 0;
        end else begin
          a.evicted = 1;
          a.evicted_id = slot_pid[o];
          drop_slot(o);
          used = flat ? units_in_use : frames_in_use;
          if (used + need > cap || empty_slot() < 0) ok = 0;
        end
      end
      if (ok && flat && need != 0) begin
        found = 0;
        run = 0;
        for (int unsigned i = 0; i < eff_total() && !found; i++) begin
          if (unit_busy[i]) run = 0;
          else begin
            run++;
            if (run == need) begin
              start = i + 1 - need;
              found = 1;
            end
          end
        end
        if (!found) ok = 0;
      end
      if (ok) begin
        int f;
        f = empty_slot();
        if (flat) begin
          for (int unsigned i = 0; i < need; i++) unit_busy[start + i] = 1;
          units_in_use += need;
        end else begin
          frames_in_use += need;
          start = 0;
        end
        slot_live[f] = 1;
        slot_pid[f] = r.process_id;
        slot_base[f] = start;
        slot_amt[f] = need;
        slot_age[f] = alloc_seq;
        alloc_seq++;
        a.status = ST_ALLOCATED;
        a.start_unit = start[START_W-1:0];
        a.pages_granted = need[SIZE_W-1:0];
      end else begin
        a.status = ST_NO_SPACE;
      end
    end
    a.used_amount = flat_mode() ? units_in_use[SIZE_W-1:0] : frames_in_use[SIZE_W-1:0];
    return a;
  endfunction

  function automatic int unsigned short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
         : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  task automatic write_reg(reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    apb.psel   <= 1'b1;
    apb.pwrite <= 1'b1;
    apb.paddr  <= APB_AW'(4 * int'(idx));
    apb.pwdata <= APB_DW'(val);
    @(posedge clk_i);
    apb.penable <= 1'b1;
    do @(posedge clk_i); while (!apb.pready);
    apb.psel    <= 1'b0;
    apb.penable <= 1'b0;
    apb.pwrite  <= 1'b0;
    if (idx == REG_TOTAL) mdl_total = val;
    else mdl_frame = val;
    wipe_allocations();
  endtask

  // Sends one request beat and records the answer the block must give.
  task automatic send_request(request_t r, bit has_ans, answer_t typed);
    answer_t a;
    // Step off the edge that closed the previous beat before driving again.
    @(posedge clk_i);
    repeat (short_gap()) @(posedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.action     <= r.action;
    req_if.process_id <= r.process_id;
    req_if.mem_size   <= r.mem_size;
    do @(posedge clk_i); while (!req_if.ready);
    req_if.valid <= 1'b0;
    a = allocate_or_free(r);
    if (has_ans && a != typed) begin
      $error("table row disagrees with predictor: %p vs %p", typed, a);
      fail_count++;
    end
    if (has_ans) a = typed;
    pending_answers = {pending_answers, a};
  endtask

  task automatic drain();
    while (pending_answers.size() != 0) @(posedge clk_i);
    // Idle margin after the last response beat before going on.
    repeat (1200) @(posedge clk_i);
  endtask

  // Response side: random stalls, then field-by-field compare on each beat.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        answer_t e;
        if (pending_answers.size() == 0) begin
          $error("response beat with nothing expected");
          fail_count++;
        end else begin
          e = pending_answers.pop_front();
          if (rsp_if.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_if.status); fail_count++;
          end
          if (rsp_if.start_unit !== e.start_unit) begin
            $error("start_unit exp %0d got %0d", e.start_unit, rsp_if.start_unit);
            fail_count++;
          end
          if (rsp_if.pages_granted !== e.pages_granted) begin
            $error("pages_granted exp %0d got %0d", e.pages_granted, rsp_if.pages_granted);
            fail_count++;
          end
          if (rsp_if.evicted !== e.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, rsp_if.evicted); fail_count++;
          end
          if (rsp_if.evicted_id !== e.evicted_id) begin
            $error("evicted_id exp %0d got %0d", e.evicted_id, rsp_if.evicted_id);
            fail_count++;
          end
          if (rsp_if.used_amount !== e.used_amount) begin
            $error("used_amount exp %0d got %0d", e.used_amount, rsp_if.used_amount);
            fail_count++;
          end
        end
      end
      // Mostly ready, with an occasional long hold.
      if ($urandom_range(0, 30) == 0) rsp_stall_long <= ~rsp_stall_long;
      rsp_if.ready <= rsp_stall_long ? ($urandom_range(0, 15) == 0)
                                     : ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: counts cycles without any accepted beat or APB access.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || apb.psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[first_fit_allocator_oldest_evict_core] ERROR");
      $finish;
    end
  end

  function automatic answer_t ans(status_e st, int su, int pg, bit ev, int eid, int used);
    answer_t a;
    a.status = st;
    a.start_unit = START_W'(su);
    a.pages_granted = SIZE_W'(pg);
    a.evicted = ev;
    a.evicted_id = ID_W'(eid);
    a.used_amount = SIZE_W'(used);
    return a;
  endfunction

  function automatic request_t rq(bit act, int pid, int sz);
    request_t r;
    r.action = act;
    r.process_id = ID_W'(pid);
    r.mem_size = SIZE_W'(sz);
    return r;
  endfunction

  // Mostly well-formed traffic: ids from a small pool so frees hit residents.
  task automatic random_phase(int n, int size_cap);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r.action = ($urandom_range(0, 9) < 4);
      r.process_id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom)
                                                 : ID_W'($urandom_range(0, 23));
      r.mem_size = ($urandom_range(0, 19) == 0) ? SIZE_W'($urandom_range(0, 2047))
                                                : SIZE_W'($urandom_range(0, size_cap));
      send_request(r, 0, '0);
    end
  endtask

  row_t directed [$];

  initial begin
    req_if.valid = 1'b0;
    req_if.action = 1'b0;
    req_if.process_id = '0;
    req_if.mem_size = '0;
    apb.psel = 1'b0;
    apb.penable = 1'b0;
    apb.pwrite = 1'b0;
    apb.paddr = '0;
    apb.pwdata = '0;
    mdl_total = TOTAL_RST;
    mdl_frame = FRAME_RST;
    alloc_seq = '0;
    wipe_allocations();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Flat mode out of reset: full-size, zero-size, resident, frees, eviction.
    directed = '{
      '{rq(1, 5, 0),     1, ans(ST_NOT_RESIDENT, 0, 0, 0, 0, 0)},
      '{rq(0, 255, 1024), 1, ans(ST_ALLOCATED, 0, 1024, 0, 0, 1024)},
      '{rq(0, 255, 3),   1, ans(ST_ALREADY, 0, 0, 0, 0, 1024)},
      '{rq(0, 0, 0),     1, ans(ST_ALLOCATED, 0, 0, 0, 0, 1024)},
      '{rq(1, 255, 0),   1, ans(ST_FREED, 0, 0, 0, 0, 0)},
      '{rq(0, 1, 2047),  1, ans(ST_NO_SPACE, 0, 0, 1, 0, 0)},
      '{rq(0, 2, 1000),  0, '0},
      '{rq(0, 3, 100),   0, '0},
      '{rq(0, 4, 24),    0, '0},
      '{rq(1, 0, 0),     0, '0},
      '{rq(0, 170, 1),   0, '0},
      '{rq(0, 85, 1),    0, '0},
      '{rq(1, 200, 2047), 0, '0}
    };
    foreach (directed[i]) send_request(directed[i].req, directed[i].has_ans, directed[i].ans);
    // Fill every slot to reach the slots-full case.
    for (int i = 0; i < NSLOTS + 2; i++) send_request(rq(0, 40 + i, 0), 0, '0);
    // Pause until everything has come back before the configuration change.
    drain();

    random_phase(150, 120);
    drain();

    // Paging: 1024 units in 64-unit frames.
    write_reg(REG_FRAME, 11'd64);
    send_request(rq(0, 9, 1024), 1, ans(ST_ALLOCATED, 0, 16, 0, 0, 16));
    send_request(rq(0, 10, 1), 1, ans(ST_ALLOCATED, 0, 1, 1, 9, 1));
    random_phase(110, 400);
    drain();

    // Zero frame size means one-unit frames; total saturates above the array.
    write_reg(REG_FRAME, 11'd0);
    write_reg(REG_TOTAL, 11'd2047);
    random_phase(60, 600);
    drain();

    // Tiny flat memory: total and frame both 1.
    write_reg(REG_TOTAL, 11'd1);
    write_reg(REG_FRAME, 11'd1);
    random_phase(50, 2);
    drain();

    // Zero total in paging mode manages nothing.
    write_reg(REG_TOTAL, 11'd0);
    random_phase(20, 5);
    drain();

    // Small flat memory for fragmentation, then back to reset values.
    write_reg(REG_TOTAL, 11'd40);
    write_reg(REG_FRAME, 11'd40);
    random_phase(100, 12);
    drain();
    write_reg(REG_TOTAL, 11'd1024);
    write_reg(REG_FRAME, 11'd1024);
    random_phase(50, 200);
    drain();

    if (fail_count == 0)
      $display("[first_fit_allocator_oldest_evict_core] OK");
    else
      $display("[first_fit_allocator_oldest_evict_core] ERROR");
    $finish;
  end

  // Checking failures from the response side count via fail_count; no leftovers
  // can remain after drain.
endmodule

### first_fit_allocator_oldest_evict_core.f
rtl/ffa_pkg.sv
rtl/ffa_req_if.sv
rtl/ffa_rsp_if.sv
rtl/ffa_div.sv
rtl/ffa_dp.sv
rtl/ffa_ctrl.sv
rtl/first_fit_allocator_oldest_evict_core.sv
rtl/ffa_chk.sv
tb/ffa_tb_if.sv
tb/first_fit_allocator_oldest_evict_core_test.sv
